[src/assert_macros.svh]
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising clock edge outside reset
`define CSD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// implication form, checked outside reset
`define CSD_ASSERT_IMP(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

`endif

[src/csd_pkg.sv]
package csd_pkg;

	localparam int CSD_QUEUE_DEPTH = 16;

	localparam int CSD_TRACK_W = 10;
	localparam int CSD_BLK_W   = 4;
	localparam int CSD_NBLK_W  = 8;
	localparam int CSD_TAG_W   = 6;

	localparam int CSD_IN_DATA_W  = 48;
	localparam int CSD_IN_USER_W  = 2;
	localparam int CSD_OUT_DATA_W = 32;
	localparam int CSD_OUT_USER_W = 3;

	// action codes
	localparam logic [1:0] ACT_ENQUEUE  = 2'd0;
	localparam logic [1:0] ACT_DISPATCH = 2'd1;
	localparam logic [1:0] ACT_COMPLETE = 2'd2;

	// result status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	// one queued request, track in the lowest bits
	typedef struct packed {
		logic [CSD_TAG_W-1:0]   tag;
		logic                   is_read;
		logic                   unit;
		logic [CSD_NBLK_W-1:0]  num_blocks;
		logic [CSD_BLK_W-1:0]   first_block;
		logic [CSD_TRACK_W-1:0] track;
	} csd_req_t;

	localparam int CSD_ENTRY_W = $bits(csd_req_t);

	// controller to datapath
	typedef struct packed {
		logic take;
		logic sweep;
		logic move;
		logic pick;
		logic commit;
	} csd_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_disp;
		logic empty;
		logic full;
		logic sweep_done;
		logic out_free;
	} csd_sts_t;

endpackage

[src/csd_ram.sv]
module csd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                      wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                      rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

[src/csd_datapath.sv]
module csd_datapath import csd_pkg::*; #(
	parameter int QUEUE_DEPTH = CSD_QUEUE_DEPTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [CSD_IN_DATA_W-1:0]  in_data,
	input  logic [CSD_IN_USER_W-1:0]  in_user,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [CSD_OUT_DATA_W-1:0] out_data,
	output logic [CSD_OUT_USER_W-1:0] out_user,
	input  csd_cmd_t                  cmd,
	output csd_sts_t                  sts
);

	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	// captured item
	logic [1:0]             act_q;
	csd_req_t               req_q;
	logic [CSD_TRACK_W-1:0] reached_q;
	logic                   reached_ok_q;

	logic [CNT_W-1:0]       count_q;
	logic [CSD_TRACK_W-1:0] head_q;

	// read sweep over the queue
	logic [CNT_W-1:0] ptr_q;
	logic             rd_v_s1;
	logic [CNT_W-1:0] rd_idx_s1;
	logic [CNT_W-1:0] shift_wa;

	// search trackers: at or above head, and overall minimum
	logic                   hi_found_q;
	logic [IDX_W-1:0]       hi_idx_q;
	logic [CSD_TRACK_W-1:0] hi_track_q;
	csd_req_t               hi_req_q;
	logic                   lo_found_q;
	logic [IDX_W-1:0]       lo_idx_q;
	logic [CSD_TRACK_W-1:0] lo_track_q;
	csd_req_t               lo_req_q;

	logic [IDX_W-1:0] sel_idx;
	csd_req_t         sel_req;

	logic                   full;
	logic                   empty;
	logic                   issue;
	logic                   ram_we;
	logic [IDX_W-1:0]       ram_wa;
	logic [CSD_ENTRY_W-1:0] ram_wd;
	logic [CSD_ENTRY_W-1:0] ram_rd;
	csd_req_t               rd_req;

	// result register
	logic       out_valid_q;
	csd_req_t   out_req_q;
	logic [1:0] out_status_q;
	logic       out_disp_q;

	csd_req_t   res_req;
	logic [1:0] res_status;
	logic       res_disp;

	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign issue    = cmd.sweep && (ptr_q < count_q);
	assign shift_wa = rd_idx_s1 - CNT_W'(1);
	assign rd_req   = csd_req_t'(ram_rd);

	assign sel_idx = hi_found_q ? hi_idx_q : lo_idx_q;
	assign sel_req = hi_found_q ? hi_req_q : lo_req_q;

	always_comb begin
		ram_we = 1'b0;
		ram_wa = count_q[IDX_W-1:0];
		ram_wd = req_q;
		if (cmd.sweep && cmd.move && rd_v_s1) begin
			ram_we = 1'b1;
			ram_wa = shift_wa[IDX_W-1:0];
			ram_wd = ram_rd;
		end else if (cmd.commit && act_q == ACT_ENQUEUE && !full) begin
			ram_we = 1'b1;
		end
	end

	csd_ram #(
		.WIDTH(CSD_ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_wa),
		.wr_data (ram_wd),
		.rd_addr (ptr_q[IDX_W-1:0]),
		.rd_data (ram_rd)
	);

	// capture and sweep control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q      <= ACT_ENQUEUE;
			ptr_q      <= '0;
			rd_v_s1    <= 1'b0;
			hi_found_q <= 1'b0;
			lo_found_q <= 1'b0;
		end else if (cmd.take) begin
			act_q      <= in_user;
			ptr_q      <= '0;
			rd_v_s1    <= 1'b0;
			hi_found_q <= 1'b0;
			lo_found_q <= 1'b0;
		end else if (cmd.pick) begin
			ptr_q   <= CNT_W'(sel_idx) + CNT_W'(1);
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
			if (issue) begin
				ptr_q <= ptr_q + CNT_W'(1);
			end
			if (cmd.sweep && !cmd.move && rd_v_s1) begin
				if (rd_req.track >= head_q &&
				    (!hi_found_q || rd_req.track < hi_track_q)) begin
					hi_found_q <= 1'b1;
				end
				if (!lo_found_q || rd_req.track < lo_track_q) begin
					lo_found_q <= 1'b1;
				end
			end
		end
	end

	// payload side of capture and search
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			req_q        <= csd_req_t'(in_data[CSD_ENTRY_W-1:0]);
			reached_q    <= in_data[CSD_ENTRY_W +: CSD_TRACK_W];
			reached_ok_q <= in_data[CSD_ENTRY_W + CSD_TRACK_W];
		end
		if (issue) begin
			rd_idx_s1 <= ptr_q;
		end
		if (!cmd.take && cmd.sweep && !cmd.move && rd_v_s1) begin
			if (rd_req.track >= head_q &&
			    (!hi_found_q || rd_req.track < hi_track_q)) begin
				hi_idx_q   <= rd_idx_s1[IDX_W-1:0];
				hi_track_q <= rd_req.track;
				hi_req_q   <= rd_req;
			end
			if (!lo_found_q || rd_req.track < lo_track_q) begin
				lo_idx_q   <= rd_idx_s1[IDX_W-1:0];
				lo_track_q <= rd_req.track;
				lo_req_q   <= rd_req;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			head_q  <= '0;
		end else if (cmd.commit) begin
			unique case (act_q)
				ACT_ENQUEUE: begin
					if (!full) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				ACT_DISPATCH: begin
					if (!empty) begin
						count_q <= count_q - CNT_W'(1);
					end
				end
				ACT_COMPLETE: begin
					if (reached_ok_q) begin
						head_q <= reached_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		res_req    = '0;
		res_status = STAT_OK;
		res_disp   = 1'b0;
		unique case (act_q)
			ACT_ENQUEUE: begin
				if (full) begin
					res_status = STAT_FULL;
				end
			end
			ACT_DISPATCH: begin
				if (empty) begin
					res_status = STAT_EMPTY;
				end else begin
					res_req  = sel_req;
					res_disp = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_req_q    <= res_req;
			out_status_q <= res_status;
			out_disp_q   <= res_disp;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {{(CSD_OUT_DATA_W - CSD_ENTRY_W){1'b0}}, out_req_q};
	assign out_user  = {out_disp_q, out_status_q};

	assign sts.is_disp    = (act_q == ACT_DISPATCH);
	assign sts.empty      = empty;
	assign sts.full       = full;
	assign sts.sweep_done = (ptr_q >= count_q) && !rd_v_s1;
	assign sts.out_free   = !out_valid_q || out_ready;

endmodule

[src/csd_ctrl.sv]
module csd_ctrl import csd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  csd_sts_t sts,
	output csd_cmd_t cmd
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_DECODE = 5'b00010,
		S_SCAN   = 5'b00100,
		S_SHIFT  = 5'b01000,
		S_FINISH = 5'b10000
	} csd_state_t;

	csd_state_t state_q;
	csd_state_t state_nxt;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take  = 1'b1;
					state_nxt = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.is_disp && !sts.empty) begin
					state_nxt = S_SCAN;
				end else begin
					state_nxt = S_FINISH;
				end
			end
			S_SCAN: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_done) begin
					cmd.pick  = 1'b1;
					state_nxt = S_SHIFT;
				end
			end
			S_SHIFT: begin
				cmd.sweep = 1'b1;
				cmd.move  = 1'b1;
				if (sts.sweep_done) begin
					state_nxt = S_FINISH;
				end
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_nxt  = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

[src/cscan_disk_request_scheduler_unit.sv]
// c-scan disk request scheduler
// input words on s_axis: tuser carries the action (enqueue, dispatch, completion),
// tdata the request fields plus the reached track for completions
// output words on m_axis: one result word per input word, tuser holds the status
// and the dispatched flag, tdata the fields of a dispatched request (zero otherwise)
// the queue keeps requests in arrival order in a single-port-read memory
// enqueue, completion, empty dispatch, unused action: the word passes through decode and
// finish, where the result is registered, and the block then returns to idle for the next word
// dispatch with queued requests: the scan state searches for the pick and the shift state
// closes the gap, with nothing to move when the newest request is picked;
// the memory is read once per entry to find the pick, then entries above it are
// moved down one slot per cycle through the same read port
// a new input word is taken the cycle after the previous result has been committed to
// the output register, even while that result still waits on m_axis_tready
// when the output register is full and not drained, the block holds its next
// result and takes no further input until the register frees up
// reset empties the queue and puts the head at track zero; no clearing pass
module cscan_disk_request_scheduler_unit
	import csd_pkg::*;
#(
	parameter int QUEUE_DEPTH = CSD_QUEUE_DEPTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	// track, first_block, num_blocks, disk_unit, is_read, requester_tag,
	// reached_track, track_reached_valid, zero pad
	input  logic [CSD_IN_DATA_W-1:0]  s_axis_tdata,
	// action
	input  logic [CSD_IN_USER_W-1:0]  s_axis_tuser,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// out_track, out_first_block, out_num_blocks, out_unit, out_is_read,
	// out_tag, zero pad
	output logic [CSD_OUT_DATA_W-1:0] m_axis_tdata,
	// result_status, dispatched
	output logic [CSD_OUT_USER_W-1:0] m_axis_tuser
);

	csd_cmd_t cmd;
	csd_sts_t sts;

	// sequencer: capture, search, close the gap, commit
	csd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// queue memory, head position, search trackers and result register
	csd_datapath #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (s_axis_tdata),
		.in_user   (s_axis_tuser),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser),
		.cmd       (cmd),
		.sts       (sts)
	);

`include "assert_macros.svh"

	// an empty queue can never also be full
	`CSD_ASSERT(a_full_empty, !(sts.full && sts.empty), "queue both full and empty")
	// a result only lands when the output register can take it
	`CSD_ASSERT_IMP(a_commit_free, cmd.commit, sts.out_free, "result committed over a held word")
	// the queue is only walked while it holds requests
	`CSD_ASSERT_IMP(a_sweep_nonempty, cmd.sweep, !sts.empty, "sweep over an empty queue")
	// no input is taken while an item is still being worked on
	`CSD_ASSERT_IMP(a_ready_idle, s_axis_tready, !cmd.sweep && !cmd.commit,
		"input ready during work")

endmodule
